// ----- rtl/sample_to_ascii_frame_top_defines.svh -----
// Assertion macros for the frame encoder.
`ifndef SAMPLE_TO_ASCII_FRAME_TOP_DEFINES_SVH
`define SAMPLE_TO_ASCII_FRAME_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame encoder check failed");
// next-cycle implication
`define STFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame encoder check failed");
`else
`define STFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/stfa_pkg.sv -----
package stfa_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned POS_W    = 11;   // scaled value, max 1638
	localparam int unsigned PROD_W   = 24;   // 13-bit (sample+1) times 11-bit scale

	localparam logic [10:0] SCALE_MUL   = 11'd1638;
	localparam int unsigned SCALE_SHIFT = 12;

	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ETX  = 8'h03;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// decimal digits of the scaled value
	typedef struct packed {
		logic       d3;   // thousands, only 0 or 1
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} digits_t;

endpackage

// ----- rtl/sample_to_ascii_frame_top.sv -----
// Channel   Dir  Bus                         Contents
// s_axis    in   s_tvalid/s_tready/s_tdata   one 12-bit converter sample per word
// m_axis    out  m_tvalid/m_tready/m_tdata   one ASCII frame byte per word, tlast on ETX
//
// Each sample becomes an 8-word frame: STX, thousands, '.', hundreds, tens,
// units, CR, ETX, where the value is (1638*sample+1638) >> 12 (0..1638).
// Output bus: one byte per cycle while m_tready is high; new samples can enter
// the pipeline while a frame is still going out. The first byte is valid once
// the sample has passed the 4 math stages and the frame register. No state
// beyond the pipeline; reset only empties it. Stalls on m_tready back-pressure
// through valid/ready on every stage; nothing is dropped or repeated.
`include "sample_to_ascii_frame_top_defines.svh"

module sample_to_ascii_frame_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] frame_byte
	output logic        m_tlast    // frame_end
);

	// digit pipeline -> frame register
	logic              dig_valid;
	logic              dig_ready;
	stfa_pkg::digits_t dig;

	// scale by 1638/4096 and peel off decimal digits, one split per stage
	stfa_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata[stfa_pkg::SAMPLE_W-1:0]),
		.out_valid (dig_valid),
		.out_ready (dig_ready),
		.digits    (dig)
	);

	// frame register doubles as the output register; it reloads in the same
	// cycle the ETX word leaves, so frames go out back to back
	stfa_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dig_valid),
		.in_ready (dig_ready),
		.digits   (dig),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// frame end always carries ETX
	`STFA_ASSERT_IMP(a_last_is_etx, clk, arst_n, m_tvalid && m_tlast, m_tdata == stfa_pkg::CH_ETX)
	// a word following a finished frame opens with STX
	`STFA_ASSERT_NXT(a_next_is_stx, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tdata == stfa_pkg::CH_STX)
	// a stalled word is not withdrawn
	`STFA_ASSERT_NXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

// ----- rtl/stfa_digits.sv -----
// Scale and split into decimal digits, four register stages.
module stfa_digits (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [stfa_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output stfa_pkg::digits_t               digits
);

	localparam int unsigned PROD_W = stfa_pkg::PROD_W;

	// stage 1: scaled value
	logic                          v_s1;
	logic [stfa_pkg::POS_W-1:0]    pos_s1;
	// stage 2: thousands split
	logic                          v_s2;
	logic                          d3_s2;
	logic [9:0]                    r_s2;
	// stage 3: hundreds split
	logic                          v_s3;
	logic                          d3_s3;
	logic [3:0]                    d2_s3;
	logic [6:0]                    r_s3;
	// stage 4: all digits
	logic                          v_s4;
	stfa_pkg::digits_t             dig_s4;

	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1 math
	logic [12:0]                   inc_c;
	logic [PROD_W-1:0]             prod1_c;
	assign inc_c   = {1'b0, sample} + 13'd1;
	assign prod1_c = PROD_W'(inc_c) * PROD_W'(stfa_pkg::SCALE_MUL);

	// stage 2 math
	logic        ge1000_c;
	logic [10:0] sub1000_c;
	assign ge1000_c  = (pos_s1 >= 11'd1000);
	assign sub1000_c = pos_s1 - 11'd1000;

	// stage 3 math: x*41 >> 12 is x/100 for x < 1000
	logic [15:0] prod3_c;
	logic [3:0]  q100_c;
	logic [9:0]  sub100_c;
	assign prod3_c  = 16'(r_s2) * 16'd41;
	assign q100_c   = prod3_c[15:12];
	assign sub100_c = r_s2 - (10'(q100_c) * 10'd100);

	// stage 4 math: x*205 >> 11 is x/10 for x < 100
	logic [14:0] prod4_c;
	logic [3:0]  q10_c;
	logic [6:0]  sub10_c;
	assign prod4_c = 15'(r_s3) * 15'd205;
	assign q10_c   = prod4_c[14:11];
	assign sub10_c = r_s3 - (7'(q10_c) * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			pos_s1 <= prod1_c[stfa_pkg::SCALE_SHIFT +: stfa_pkg::POS_W];
		end
		if (rdy2 && v_s1) begin
			d3_s2 <= ge1000_c;
			r_s2  <= ge1000_c ? sub1000_c[9:0] : pos_s1[9:0];
		end
		if (rdy3 && v_s2) begin
			d3_s3 <= d3_s2;
			d2_s3 <= q100_c;
			r_s3  <= sub100_c[6:0];
		end
		if (rdy4 && v_s3) begin
			dig_s4.d3 <= d3_s3;
			dig_s4.d2 <= d2_s3;
			dig_s4.d1 <= q10_c;
			dig_s4.d0 <= sub10_c[3:0];
		end
	end

	assign out_valid = v_s4;
	assign digits    = dig_s4;

endmodule

// ----- rtl/stfa_serializer.sv -----
// Holds one frame and sends it a byte per word; reloads on the ETX handoff.
module stfa_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stfa_pkg::digits_t digits,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	localparam logic [2:0] POS_STX = 3'd0;
	localparam logic [2:0] POS_D3  = 3'd1;
	localparam logic [2:0] POS_DOT = 3'd2;
	localparam logic [2:0] POS_D2  = 3'd3;
	localparam logic [2:0] POS_D1  = 3'd4;
	localparam logic [2:0] POS_D0  = 3'd5;
	localparam logic [2:0] POS_CR  = 3'd6;
	localparam logic [2:0] POS_ETX = 3'd7;

	logic              busy_q;
	logic [2:0]        idx_q;
	stfa_pkg::digits_t dig_q;
	logic              load;
	logic              at_end;

	assign at_end   = (idx_q == POS_ETX);
	assign in_ready = !busy_q || (m_tready && at_end);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= POS_STX;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= POS_STX;
		end else if (busy_q && m_tready) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= digits;
		end
	end

	always_comb begin
		unique case (idx_q)
			POS_STX: m_tdata = stfa_pkg::CH_STX;
			POS_D3:  m_tdata = stfa_pkg::CH_ZERO + {7'd0, dig_q.d3};
			POS_DOT: m_tdata = stfa_pkg::CH_DOT;
			POS_D2:  m_tdata = stfa_pkg::CH_ZERO + {4'd0, dig_q.d2};
			POS_D1:  m_tdata = stfa_pkg::CH_ZERO + {4'd0, dig_q.d1};
			POS_D0:  m_tdata = stfa_pkg::CH_ZERO + {4'd0, dig_q.d0};
			POS_CR:  m_tdata = stfa_pkg::CH_CR;
			POS_ETX: m_tdata = stfa_pkg::CH_ETX;
			default: m_tdata = stfa_pkg::CH_ETX;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = at_end;

endmodule
